// ===== src/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher block.
// No dependencies; compile before the RTL modules.
package rc4_pkg;

	typedef logic [7:0] byte_t;

	localparam int SBOX_SIZE     = 256;
	localparam int KEY_MAX_BYTES = 256;
	localparam int KEY_CNT_W     = 9;
	localparam int STATE_W       = 4;

	typedef logic [KEY_CNT_W-1:0] key_cnt_t;

	localparam key_cnt_t KEY_LIMIT = KEY_CNT_W'(KEY_MAX_BYTES);

	typedef enum logic {
		OP_KEY  = 1'b0,
		OP_DATA = 1'b1
	} opcode_t;

endpackage

// ===== src/rc4_stream_cipher.sv =====
// RC4 stream cipher block: key store, S-box memory, sequencer and output register.
// Depends on rc4_pkg.
//
// Send key bytes with opcode set to key; the byte marked key_last runs the key
// schedule over the bytes stored so far (up to 256; extra key bytes are dropped)
// and clears both stream indices. A key byte without the mark only goes to the key store.
// The marked key byte first loads the identity permutation (ST_FILL), then runs
// one swap step per S-box entry through ST_K0 to ST_K3; the single S-box
// memory with one read and one write port sets the step count. A data byte
// runs ST_D0 to ST_D5 and may wait in ST_D5 for the output register: two
// dependent reads (S[i], then S[j]), two write-backs and the keystream read,
// all through the single S-box memory, then the output load.
// One result leaves per data byte and none per key byte. The block takes a new
// transaction while a finished result still waits on the output register. Send
// data only after a completed key load; before that the S-box contents are unknown.
module rc4_stream_cipher
	import rc4_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	input  logic  opcode,
	input  byte_t byte_value,
	input  logic  key_last,
	output logic  result_valid,
	input  logic  result_stall,
	output byte_t data_out
);

	// Sequencer codes
	localparam logic [STATE_W-1:0] ST_IDLE = 4'd0;
	localparam logic [STATE_W-1:0] ST_FILL = 4'd1;
	localparam logic [STATE_W-1:0] ST_K0   = 4'd2;
	localparam logic [STATE_W-1:0] ST_K1   = 4'd3;
	localparam logic [STATE_W-1:0] ST_K2   = 4'd4;
	localparam logic [STATE_W-1:0] ST_K3   = 4'd5;
	localparam logic [STATE_W-1:0] ST_D0   = 4'd6;
	localparam logic [STATE_W-1:0] ST_D1   = 4'd7;
	localparam logic [STATE_W-1:0] ST_D2   = 4'd8;
	localparam logic [STATE_W-1:0] ST_D3   = 4'd9;
	localparam logic [STATE_W-1:0] ST_D4   = 4'd10;
	localparam logic [STATE_W-1:0] ST_D5   = 4'd11;

	logic [STATE_W-1:0] state_q;

	// Memories: S-box and key store
	byte_t perm_mem [SBOX_SIZE];
	byte_t key_mem  [SBOX_SIZE];
	byte_t pb_rdata_q;
	byte_t ks_rdata_q;

	logic  pb_we;
	byte_t pb_waddr;
	byte_t pb_wdata;
	byte_t pb_raddr;
	logic  ks_we;

	// Control and datapath registers
	key_cnt_t key_count_q;
	key_cnt_t len_q;
	byte_t    kidx_q;
	byte_t    n_q;
	byte_t    i_q;
	byte_t    j_q;
	byte_t    t_q;
	byte_t    r_q;
	byte_t    byte_q;
	logic     result_valid_q;
	byte_t    data_out_q;

	logic     accept;
	logic     key_room;
	key_cnt_t len_next;
	byte_t    j_sched;
	byte_t    j_stream;
	logic     kidx_wrap;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign key_room     = (key_count_q < KEY_LIMIT);
	// A stored marked byte counts toward the schedule length
	assign len_next     = key_room ? key_count_q + key_cnt_t'(1) : key_count_q;
	assign ks_we        = accept && (opcode == OP_KEY) && key_room;
	assign j_sched      = j_q + pb_rdata_q + ks_rdata_q;
	assign j_stream     = j_q + pb_rdata_q;
	assign kidx_wrap    = ({1'b0, kidx_q} + key_cnt_t'(1)) == len_q;
	assign result_valid = result_valid_q;
	assign data_out     = data_out_q;

	// S-box port steering
	always_comb begin
		pb_we    = 1'b0;
		pb_waddr = n_q;
		pb_wdata = n_q;
		pb_raddr = r_q;
		case (state_q)
			ST_FILL: begin
				pb_we = 1'b1;
			end
			ST_K0:   pb_raddr = n_q;
			ST_K1:   pb_raddr = j_sched;
			ST_K2: begin
				pb_we    = 1'b1;
				pb_wdata = pb_rdata_q;
			end
			ST_K3: begin
				pb_we    = 1'b1;
				pb_waddr = j_q;
				pb_wdata = t_q;
			end
			ST_D0:   pb_raddr = i_q + 8'd1;
			ST_D1:   pb_raddr = j_stream;
			ST_D2: begin
				pb_we    = 1'b1;
				pb_waddr = i_q;
				pb_wdata = pb_rdata_q;
			end
			ST_D3: begin
				pb_we    = 1'b1;
				pb_waddr = j_q;
				pb_wdata = t_q;
			end
			ST_D4:   pb_raddr = r_q;
			default: pb_raddr = r_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pb_we) begin
			perm_mem[pb_waddr] <= pb_wdata;
		end
		pb_rdata_q <= perm_mem[pb_raddr];
	end

	always_ff @(posedge clk) begin
		if (ks_we) begin
			key_mem[key_count_q[7:0]] <= byte_value;
		end
		ks_rdata_q <= key_mem[kidx_q];
	end

	// Payload registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= byte_value;
		end
		if (state_q == ST_K1 || state_q == ST_D1) begin
			t_q <= pb_rdata_q;
		end
		if (state_q == ST_D2) begin
			// New S[i] plus new S[j]: the swapped pair
			r_q <= t_q + pb_rdata_q;
		end
		if (state_q == ST_D5 && !(result_valid_q && result_stall)) begin
			data_out_q <= byte_q ^ pb_rdata_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			key_count_q    <= '0;
			len_q          <= '0;
			kidx_q         <= '0;
			n_q            <= '0;
			i_q            <= '0;
			j_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// Raise on a finished data byte, drop once the receiver takes it
			if (state_q == ST_D5 && !(result_valid_q && result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_DATA) begin
							state_q <= ST_D0;
						end else if (key_last) begin
							// Start the schedule and open a fresh key load
							len_q       <= len_next;
							key_count_q <= '0;
							n_q         <= '0;
							state_q     <= ST_FILL;
						end else begin
							key_count_q <= len_next;
						end
					end
				end
				ST_FILL: begin
					n_q <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						j_q     <= '0;
						kidx_q  <= '0;
						state_q <= ST_K0;
					end
				end
				ST_K0: state_q <= ST_K1;
				ST_K1: begin
					j_q     <= j_sched;
					state_q <= ST_K2;
				end
				ST_K2: state_q <= ST_K3;
				ST_K3: begin
					kidx_q <= kidx_wrap ? 8'd0 : kidx_q + 8'd1;
					n_q    <= n_q + 8'd1;
					if (n_q == 8'hFF) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_K0;
					end
				end
				ST_D0: begin
					i_q     <= i_q + 8'd1;
					state_q <= ST_D1;
				end
				ST_D1: begin
					j_q     <= j_stream;
					state_q <= ST_D2;
				end
				ST_D2: state_q <= ST_D3;
				ST_D3: state_q <= ST_D4;
				ST_D4: state_q <= ST_D5;
				ST_D5: begin
					// Hold until the output register is free
					if (!(result_valid_q && result_stall)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_key_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= KEY_LIMIT)
		else $error("key count beyond store size");

	a_len_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_K0) |-> (len_q != '0 && len_q <= KEY_LIMIT))
		else $error("schedule length out of range");

	a_kidx_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_K0) |-> ({1'b0, kidx_q} < len_q))
		else $error("key index past schedule length");

	a_data_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_DATA) |=> (state_q == ST_D0))
		else $error("data transaction did not start the stream sequence");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q) == ST_D5)
		else $error("result raised outside the final stream step");
`endif

endmodule
